/* sv/srfp_pkg.sv */
`default_nettype none

package srfp_pkg;

    localparam logic [7:0] CH_START = 8'h40;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_END   = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int DIGITS = 4;

    localparam logic [1:0] SIGN_NONE  = 2'd0;
    localparam logic [1:0] SIGN_PLUS  = 2'd1;
    localparam logic [1:0] SIGN_MINUS = 2'd2;

    // Accepted characters after the start byte that a terminator needs.
    localparam logic [2:0] POS_END_MIN = 3'd3;
    localparam logic [2:0] POS_END_MAX = 3'd4;
    localparam logic [2:0] POS_DIGIT_MAX = 3'd3;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'b01,
        MODE_FRAME = 2'b10
    } t_mode;

    typedef struct packed {
        t_mode                  mode;
        logic [2:0]             pos;
        logic [1:0]             sign;
        logic [DIGITS-1:0][3:0] digits;
    } t_state;

    typedef struct packed {
        logic                   frame_done;
        logic [1:0]             sign_code;
        logic [2:0]             digit_count;
        logic [DIGITS-1:0][3:0] digits;
    } t_result;

    localparam t_state STATE_RESET = '{
        mode:   MODE_IDLE,
        pos:    3'd0,
        sign:   SIGN_NONE,
        digits: '0
    };

endpackage

`default_nettype wire

/* sv/signed_reading_frame_parser.sv */
// Signed reading frame parser.
// Input channel: one received byte per transfer on i_rx_byte, i_valid/o_stall.
// Output channel: one result per byte on the o_* fields, o_valid/i_stall.
// Frames: '@', an optional '+' or '-', 3-4 digits (2-3 after a sign), '#'.
// A result with o_frame_done high carries the sign code, the digit count and
// the digits in BCD; every other byte gives an all-zero result.
// Pipeline: a taken byte is registered in the input stage, parsed against
// the frame state and written to the result buffer, from which its result
// transfers on the output channel.
// Throughput: one byte per cycle while the result buffer is not full; the
// parse is a single compare-and-update step on the frame state register.
// Stall: a two-entry result buffer lets the input keep flowing after i_stall
// rises; once it is full and a byte waits, o_stall holds the input side.
// Reset (synchronous, active low): frame state goes idle with cleared sign
// and digits, both stages empty, no result shown and o_stall low.
`default_nettype none

module signed_reading_frame_parser (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       i_valid,
    output logic           o_stall,
    input  var logic [7:0] i_rx_byte,
    output logic           o_valid,
    input  var logic       i_stall,
    output logic           o_frame_done,
    output logic [1:0]     o_sign_code,
    output logic [2:0]     o_digit_count,
    output logic [3:0]     o_digit_first,
    output logic [3:0]     o_digit_second,
    output logic [3:0]     o_digit_third,
    output logic [3:0]     o_digit_fourth
);
    import srfp_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    t_state     r_state;
    t_state     n_state;
    t_result    step_result;
    t_result    out_data;
    logic       buf_full;
    logic       advance;
    logic       in_take;

    assign advance = r_in_valid && !buf_full;
    assign o_stall = r_in_valid && buf_full;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_rx_byte;
        end
    end

    srfp_step u_step (
        .i_state  (r_state),
        .i_byte   (r_in_byte),
        .o_state  (n_state),
        .o_result (step_result)
    );

    // Advance the frame state only when the byte moves into the result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    srfp_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (advance),
        .i_data  (step_result),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_data  (out_data)
    );

    assign o_frame_done   = out_data.frame_done;
    assign o_sign_code    = out_data.sign_code;
    assign o_digit_count  = out_data.digit_count;
    assign o_digit_first  = out_data.digits[0];
    assign o_digit_second = out_data.digits[1];
    assign o_digit_third  = out_data.digits[2];
    assign o_digit_fourth = out_data.digits[3];

endmodule

`default_nettype wire

/* sv/srfp_step.sv */
`default_nettype none

module srfp_step (
    input  var srfp_pkg::t_state  i_state,
    input  var logic [7:0]        i_byte,
    output srfp_pkg::t_state      o_state,
    output srfp_pkg::t_result     o_result
);
    import srfp_pkg::*;

    logic       has_sign;
    logic [1:0] digit_idx;

    assign has_sign  = (i_state.sign != SIGN_NONE);
    assign digit_idx = i_state.pos[1:0] - {1'b0, has_sign};

    always_comb begin
        o_state  = i_state;
        o_result = '0;
        case (i_state.mode)
            MODE_IDLE: begin
                if (i_byte == CH_START) begin
                    o_state.mode   = MODE_FRAME;
                    o_state.pos    = 3'd0;
                    o_state.sign   = SIGN_NONE;
                    o_state.digits = '0;
                end
            end
            MODE_FRAME: begin
                case (i_byte) inside
                    CH_PLUS, CH_MINUS: begin
                        if (i_state.pos == 3'd0) begin
                            o_state.sign = (i_byte == CH_PLUS) ? SIGN_PLUS : SIGN_MINUS;
                            o_state.pos  = 3'd1;
                        end else begin
                            o_state.mode = MODE_IDLE;
                            o_state.pos  = 3'd0;
                        end
                    end
                    [CH_ZERO:CH_NINE]: begin
                        if (i_state.pos <= POS_DIGIT_MAX) begin
                            // ASCII digits carry their BCD value in the low nibble
                            o_state.digits[digit_idx] = i_byte[3:0];
                            o_state.pos = i_state.pos + 3'd1;
                        end else begin
                            o_state.mode = MODE_IDLE;
                            o_state.pos  = 3'd0;
                        end
                    end
                    CH_END: begin
                        if (i_state.pos == POS_END_MIN || i_state.pos == POS_END_MAX) begin
                            o_result.frame_done  = 1'b1;
                            o_result.sign_code   = i_state.sign;
                            o_result.digit_count = i_state.pos - {2'b00, has_sign};
                            o_result.digits      = i_state.digits;
                        end
                        o_state.mode = MODE_IDLE;
                        o_state.pos  = 3'd0;
                    end
                    default: begin
                        // drop the frame
                        o_state.mode = MODE_IDLE;
                        o_state.pos  = 3'd0;
                    end
                endcase
            end
            default: begin
                o_state = STATE_RESET;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/srfp_outbuf.sv */
`default_nettype none

module srfp_outbuf (
    input  var logic              i_clk,
    input  var logic              i_rst_n,
    input  var logic              i_push,
    input  var srfp_pkg::t_result i_data,
    output logic                  o_full,
    output logic                  o_valid,
    input  var logic              i_stall,
    output srfp_pkg::t_result     o_data
);
    import srfp_pkg::*;

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_result    r_head;
    t_result    r_skid;
    logic       pop;

    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;
    assign pop     = o_valid && !i_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (r_count == 2'd2) begin
                r_head <= r_skid;
            end else if (i_push) begin
                r_head <= i_data;
            end
        end else if (i_push) begin
            if (r_count == 2'd0) begin
                r_head <= i_data;
            end else begin
                r_skid <= i_data;
            end
        end
    end

endmodule

`default_nettype wire

/* sv/srfp_checker.sv */
`default_nettype none

module srfp_checker (
    input  var logic       i_clk,
    input  var logic       i_rst_n,
    input  var logic       o_stall,
    input  var logic       o_valid,
    input  var logic       i_stall,
    input  var logic       o_frame_done,
    input  var logic [1:0] o_sign_code,
    input  var logic [2:0] o_digit_count,
    input  var logic [3:0] o_digit_first,
    input  var logic [3:0] o_digit_second,
    input  var logic [3:0] o_digit_third,
    input  var logic [3:0] o_digit_fourth
);

    // Reset empties both stages.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && !o_stall))
        else $error("result or stall shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_frame_done)
            && $stable(o_sign_code) && $stable(o_digit_count)
            && $stable(o_digit_first) && $stable(o_digit_second)
            && $stable(o_digit_third) && $stable(o_digit_fourth)))
        else $error("stalled result changed");

    a_drop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_frame_done) |-> (o_sign_code == 2'd0
            && o_digit_count == 3'd0 && o_digit_first == 4'd0
            && o_digit_second == 4'd0 && o_digit_third == 4'd0
            && o_digit_fourth == 4'd0))
        else $error("non-frame result not all zero");

    a_frame_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done) |-> ((o_digit_count == 3'd2
            || o_digit_count == 3'd3 || o_digit_count == 3'd4)
            && o_sign_code != 2'd3 && o_digit_first <= 4'd9
            && o_digit_second <= 4'd9 && o_digit_third <= 4'd9
            && o_digit_fourth <= 4'd9))
        else $error("completed frame out of shape");

    a_short_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_frame_done && o_digit_count == 3'd2)
            |-> (o_digit_third == 4'd0 && o_digit_fourth == 4'd0))
        else $error("two-digit frame carries extra digits");

endmodule

bind signed_reading_frame_parser srfp_checker u_srfp_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_frame_done   (o_frame_done),
    .o_sign_code    (o_sign_code),
    .o_digit_count  (o_digit_count),
    .o_digit_first  (o_digit_first),
    .o_digit_second (o_digit_second),
    .o_digit_third  (o_digit_third),
    .o_digit_fourth (o_digit_fourth)
);

`default_nettype wire
